// ===== rtl/angle_kalman_filter_defines.svh =====
// ---------------------------------------------------------------------------
// Angle Kalman filter assertion macros
// Shared macros for the concurrent checks of the filter block.
// ---------------------------------------------------------------------------
`ifndef ANGLE_KALMAN_FILTER_DEFINES_SVH
`define ANGLE_KALMAN_FILTER_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define AKF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("angle_kalman_filter check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define AKF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("angle_kalman_filter check failed");

`endif

// ===== rtl/akf_pkg.sv =====
// ---------------------------------------------------------------------------
// Angle Kalman filter package
// Widths, payload types, sequencer codes and saturating fixed-point helpers.
// ---------------------------------------------------------------------------
package akf_pkg;

   localparam int DATA_W  = 32;
   localparam int STATE_W = 48;
   localparam int FRAC_W  = 24;
   localparam int MUL_STEPS = STATE_W;
   localparam int DIV_STEPS = STATE_W + FRAC_W;
   localparam int CNT_W = $clog2(DIV_STEPS + 1);
   localparam int ACC_W  = 25;
   localparam int RATE_W = 28;
   localparam int CFG_W  = 32;

   localparam logic signed [STATE_W-1:0] STATE_MAX = {1'b0, {(STATE_W-1){1'b1}}};
   localparam logic signed [STATE_W-1:0] STATE_MIN = {1'b1, {(STATE_W-1){1'b0}}};
   localparam logic signed [STATE_W-1:0] STATE_ONE = STATE_W'(1) << FRAC_W;

   typedef logic signed [STATE_W-1:0] state_type;

   typedef struct packed {
      logic signed [ACC_W-1:0]  accel_angle;
      logic signed [RATE_W-1:0] gyro_rate;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] angle_estimate;
      logic signed [DATA_W-1:0] bias_estimate;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      REG_SAMPLE_PERIOD = 2'd0,
      REG_ANGLE_NOISE   = 2'd1,
      REG_BIAS_NOISE    = 2'd2,
      REG_MEASURE_NOISE = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_OUTPUT
   } state_fsm_type;

   typedef enum logic [3:0] {
      OP_PRED_ANGLE,
      OP_PRED_P00,
      OP_PRED_P01,
      OP_PRED_P11,
      OP_GAIN0,
      OP_GAIN1,
      OP_UPD_P00,
      OP_UPD_P01,
      OP_UPD_P10,
      OP_UPD_P11,
      OP_CORR_ANGLE,
      OP_CORR_BIAS
   } op_type;

   function automatic logic [STATE_W-1:0] mag_of(input state_type v);
      return v[STATE_W-1] ? (~v) + STATE_W'(1) : v;
   endfunction

   function automatic state_type sat_mag(input logic neg, input logic ovf,
                                         input logic [STATE_W-1:0] m);
      if (ovf) begin
         return neg ? STATE_MIN : STATE_MAX;
      end
      return neg ? state_type'((~m) + STATE_W'(1)) : state_type'(m);
   endfunction

   function automatic state_type sadd(input state_type a, input state_type b);
      logic signed [STATE_W:0] s;
      s = {a[STATE_W-1], a} + {b[STATE_W-1], b};
      if (s[STATE_W] != s[STATE_W-1]) begin
         return s[STATE_W] ? STATE_MIN : STATE_MAX;
      end
      return s[STATE_W-1:0];
   endfunction

   function automatic state_type ssub(input state_type a, input state_type b);
      logic signed [STATE_W:0] s;
      s = {a[STATE_W-1], a} - {b[STATE_W-1], b};
      if (s[STATE_W] != s[STATE_W-1]) begin
         return s[STATE_W] ? STATE_MIN : STATE_MAX;
      end
      return s[STATE_W-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] to_out(input state_type st);
      state_type adj;
      logic signed [STATE_W-9:0] q;
      adj = st + (st[STATE_W-1] ? STATE_W'(255) : STATE_W'(0));
      q = adj[STATE_W-1:8];
      if (q[STATE_W-9:DATA_W-1] != {(STATE_W-8-DATA_W+1){q[STATE_W-9]}}) begin
         return q[STATE_W-9] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
      return q[DATA_W-1:0];
   endfunction

endpackage

// ===== rtl/akf_mul.sv =====
// ---------------------------------------------------------------------------
// Serial fractional multiplier
// Shift-and-add over one multiplier bit per cycle; returns (a * b) >> 24,
// rounded towards zero and saturated to the state width.
// ---------------------------------------------------------------------------
module akf_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  akf_pkg::state_type a,
   input  akf_pkg::state_type b,
   output logic              done,
   output akf_pkg::state_type result
);
   import akf_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic [STATE_W-1:0]     mcand_ff, mcand_in;
   logic [2*STATE_W-1:0]   prod_ff, prod_in;
   logic [STATE_W:0]       sum;

   always_comb begin
      sum = {1'b0, prod_ff[2*STATE_W-1:STATE_W]}
          + (prod_ff[0] ? {1'b0, mcand_ff} : {(STATE_W+1){1'b0}});
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      mcand_in = mcand_ff;
      prod_in  = prod_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         neg_in   = a[STATE_W-1] ^ b[STATE_W-1];
         mcand_in = mag_of(a);
         prod_in  = {{STATE_W{1'b0}}, mag_of(b)};
      end else if (busy_ff) begin
         prod_in = {sum, prod_ff[STATE_W-1:1]};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      mcand_ff <= mcand_in;
      prod_ff  <= prod_in;
   end

   assign done   = done_ff;
   assign result = sat_mag(neg_ff, |prod_ff[2*STATE_W-1:FRAC_W+STATE_W-1],
                           prod_ff[FRAC_W+STATE_W-1:FRAC_W]);

endmodule

// ===== rtl/akf_div.sv =====
// ---------------------------------------------------------------------------
// Serial fractional divider
// Restoring division, one quotient bit per cycle; returns (n << 24) / d,
// rounded towards zero and saturated to the state width.
// ---------------------------------------------------------------------------
module akf_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  akf_pkg::state_type n,
   input  akf_pkg::state_type d,
   output logic              done,
   output akf_pkg::state_type result
);
   import akf_pkg::*;

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      neg_ff, neg_in;
   logic [STATE_W-1:0]        dvs_ff, dvs_in;
   logic [STATE_W-1:0]        rem_ff, rem_in;
   logic [DIV_STEPS-1:0]      num_ff, num_in;
   logic [DIV_STEPS-1:0]      quo_ff, quo_in;
   logic [STATE_W:0]          r2;
   logic [STATE_W:0]          diff;
   logic                      ge;

   always_comb begin
      r2   = {rem_ff, num_ff[DIV_STEPS-1]};
      diff = r2 - {1'b0, dvs_ff};
      ge   = r2 >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         neg_in  = n[STATE_W-1];
         dvs_in  = d;
         rem_in  = '0;
         num_in  = {mag_of(n), {FRAC_W{1'b0}}};
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[STATE_W-1:0] : r2[STATE_W-1:0];
         quo_in = {quo_ff[DIV_STEPS-2:0], ge};
         num_in = {num_ff[DIV_STEPS-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
   end

   assign done   = done_ff;
   assign result = sat_mag(neg_ff, |quo_ff[DIV_STEPS-1:STATE_W-1], quo_ff[STATE_W-1:0]);

endmodule

// ===== rtl/angle_kalman_filter.sv =====
// ---------------------------------------------------------------------------
// Angle Kalman filter
// Two-state filter fusing an accelerometer angle with a gyro rate, estimating
// angle and gyro bias in saturating fixed point.
//
//   Channel   Ports                        Direction
//   req       req_valid/req_stall/req_data  in: accel angle and gyro rate
//   rsp       rsp_valid/rsp_stall/rsp_data  out: angle and bias estimates
//   csr       csr_valid/csr_ready/index/data in: register writes
//
// Each sample runs ten serial multiplies and two serial divides, issued one
// after another on the two units.
// A new sample is taken only while the sequencer is idle.
// Synchronous reset restores the registers and the covariance to identity.
// The result register holds a beat under rsp_stall; the next sample may run
// meanwhile but waits at its end until the register is free.
// ---------------------------------------------------------------------------
`include "angle_kalman_filter_defines.svh"

module angle_kalman_filter (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  akf_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output akf_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [akf_pkg::CFG_W-1:0] csr_data
);
   import akf_pkg::*;

   state_fsm_type    state_ff, state_in;
   op_type           op_ff, op_in;
   logic [23:0]      dt_ff, an_ff, bn_ff;
   logic [31:0]      mn_ff;
   req_payload_type  smp_ff;
   state_type        angle_ff, angle_in, bias_ff, bias_in;
   state_type        p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   state_type        k0_ff, k0_in, k1_ff, k1_in;
   state_type        t0_ff, t0_in, t1_ff, t1_in, err_ff, err_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_data_ff, rsp_data_in;

   state_type        op_a, op_b, mul_res, div_res, acc_q, rate_q, dt_q, e_val;
   logic             op_is_div, mul_start, div_start, mul_done, div_done;
   logic             unit_done, wb_en, out_free, accept;

   assign acc_q  = state_type'({{(STATE_W-ACC_W-8){smp_ff.accel_angle[ACC_W-1]}},
                               smp_ff.accel_angle, 8'b0});
   assign rate_q = state_type'({{(STATE_W-RATE_W-8){smp_ff.gyro_rate[RATE_W-1]}},
                               smp_ff.gyro_rate, 8'b0});
   assign dt_q   = state_type'({{(STATE_W-24){1'b0}}, dt_ff});
   assign e_val  = sadd(state_type'({{(STATE_W-32){1'b0}}, mn_ff}), p00_ff);
   assign op_is_div = (op_ff == OP_GAIN0) || (op_ff == OP_GAIN1);
   assign unit_done = op_is_div ? div_done : mul_done;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      case (op_ff)
         OP_PRED_ANGLE: begin op_a = ssub(rate_q, bias_ff); op_b = dt_q; end
         OP_PRED_P00: begin
            op_a = ssub(ssub(state_type'({{(STATE_W-24){1'b0}}, an_ff}), p01_ff), p10_ff);
            op_b = dt_q;
         end
         OP_PRED_P01:   begin op_a = p11_ff; op_b = dt_q; end
         OP_PRED_P11:   begin op_a = state_type'({{(STATE_W-24){1'b0}}, bn_ff}); op_b = dt_q; end
         OP_GAIN0:      begin op_a = p00_ff; op_b = e_val; end
         OP_GAIN1:      begin op_a = p10_ff; op_b = e_val; end
         OP_UPD_P00:    begin op_a = k0_ff; op_b = t0_ff; end
         OP_UPD_P01:    begin op_a = k0_ff; op_b = t1_ff; end
         OP_UPD_P10:    begin op_a = k1_ff; op_b = t0_ff; end
         OP_UPD_P11:    begin op_a = k1_ff; op_b = t1_ff; end
         OP_CORR_ANGLE: begin op_a = k0_ff; op_b = err_ff; end
         OP_CORR_BIAS:  begin op_a = k1_ff; op_b = err_ff; end
         default:       begin op_a = '0; op_b = '0; end
      endcase
   end

   akf_mul u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .a(op_a), .b(op_b), .done(mul_done), .result(mul_res)
   );

   akf_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .n(op_a), .d(op_b), .done(div_done), .result(div_res)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_ISSUE;
         ST_ISSUE:  state_in = ST_WAIT;
         ST_WAIT: begin
            if (unit_done) state_in = (op_ff == OP_CORR_BIAS) ? ST_OUTPUT : ST_ISSUE;
         end
         ST_OUTPUT: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = state_ff != ST_IDLE;
      mul_start = (state_ff == ST_ISSUE) && !op_is_div;
      div_start = (state_ff == ST_ISSUE) && op_is_div;
      wb_en     = (state_ff == ST_WAIT) && unit_done;
      csr_ready = 1'b1;
   end

   always_comb begin
      op_in = op_ff;
      angle_in = angle_ff; bias_in = bias_ff;
      p00_in = p00_ff; p01_in = p01_ff; p10_in = p10_ff; p11_in = p11_ff;
      k0_in = k0_ff; k1_in = k1_ff; t0_in = t0_ff; t1_in = t1_ff; err_in = err_ff;
      if (accept) op_in = OP_PRED_ANGLE;
      if (wb_en) begin
         op_in = op_type'(op_ff + 4'd1);
         case (op_ff)
            OP_PRED_ANGLE: angle_in = sadd(angle_ff, mul_res);
            OP_PRED_P00:   p00_in = sadd(p00_ff, mul_res);
            OP_PRED_P01: begin
               p01_in = ssub(p01_ff, mul_res);
               p10_in = ssub(p10_ff, mul_res);
            end
            OP_PRED_P11:   p11_in = sadd(p11_ff, mul_res);
            OP_GAIN0: begin
               k0_in  = e_val[STATE_W-1] || (e_val == '0) ? '0 : div_res;
               t0_in  = p00_ff;
               t1_in  = p01_ff;
               err_in = ssub(acc_q, angle_ff);
            end
            OP_GAIN1:      k1_in = e_val[STATE_W-1] || (e_val == '0) ? '0 : div_res;
            OP_UPD_P00:    p00_in = ssub(p00_ff, mul_res);
            OP_UPD_P01:    p01_in = ssub(p01_ff, mul_res);
            OP_UPD_P10:    p10_in = ssub(p10_ff, mul_res);
            OP_UPD_P11:    p11_in = ssub(p11_ff, mul_res);
            OP_CORR_ANGLE: angle_in = sadd(angle_ff, mul_res);
            OP_CORR_BIAS:  bias_in = sadd(bias_ff, mul_res);
            default:       op_in = op_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if ((state_ff == ST_OUTPUT) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in.angle_estimate = to_out(angle_ff);
         rsp_data_in.bias_estimate  = to_out(bias_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_PRED_ANGLE;
         rsp_valid_ff <= 1'b0;
         dt_ff <= 24'd83886;
         an_ff <= 24'd16777;
         bn_ff <= 24'd50332;
         mn_ff <= 32'd8388608;
         angle_ff <= '0;
         bias_ff  <= '0;
         p00_ff   <= STATE_ONE;
         p01_ff   <= '0;
         p10_ff   <= '0;
         p11_ff   <= STATE_ONE;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_SAMPLE_PERIOD: dt_ff <= csr_data[23:0];
               REG_ANGLE_NOISE:   an_ff <= csr_data[23:0];
               REG_BIAS_NOISE:    bn_ff <= csr_data[23:0];
               REG_MEASURE_NOISE: mn_ff <= csr_data;
               default:           mn_ff <= mn_ff;
            endcase
         end
         angle_ff <= angle_in;
         bias_ff  <= bias_in;
         p00_ff   <= p00_in;
         p01_ff   <= p01_in;
         p10_ff   <= p10_in;
         p11_ff   <= p11_in;
      end
      if (accept) smp_ff <= req_data;
      k0_ff <= k0_in;
      k1_ff <= k1_in;
      t0_ff <= t0_in;
      t1_ff <= t1_in;
      err_ff <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `AKF_ASSERT_NOW(a_mul_op, mul_done, (state_ff == ST_WAIT) && !op_is_div)
   `AKF_ASSERT_NOW(a_div_op, div_done, (state_ff == ST_WAIT) && op_is_div)
   `AKF_ASSERT_NEXT(a_issue_wait, state_ff == ST_ISSUE, state_ff == ST_WAIT)

endmodule
